>>> design/ipq_pkg.sv
// Shared types and character constants for the IPv4 dotted-quad parser.
// No dependencies; used by every module of the block except ipq_checker.
package ipq_pkg;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [9:0] OCTET_MAX = 10'd255;
  localparam logic [2:0] SAT_LIMIT = 3'd4;
  localparam logic [2:0] DIGITS_MAX = 3'd3;
  localparam logic [2:0] DOTS_NEEDED = 3'd3;

  // One input transaction: a character and its end-of-string mark.
  typedef struct packed {
    logic [7:0] character;
    logic       final_char;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
  } result_t;

endpackage

>>> design/ipq_in_reg.sv
// Input register stage of the dotted-quad parser.
// Depends on ipq_pkg for the item type.
module ipq_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  ipq_pkg::item_t in_item,
  output logic          in_stall,
  input  logic          adv,
  output logic          s1_valid,
  output ipq_pkg::item_t s1_item
);

  logic s1_valid_next;
  logic accept;

  assign in_stall = s1_valid && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (accept) begin
      s1_valid_next = 1'b1;
    end else if (adv) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

endmodule

>>> design/ipq_parse.sv
// Per-character parse state and update logic.
// Depends on ipq_pkg for types and character constants.
module ipq_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  ipq_pkg::item_t  s1_item,
  output ipq_pkg::result_t result
);

  logic [23:0] upper_octets, upper_octets_next;
  logic [9:0]  octet_value, octet_value_next;
  logic [2:0]  digit_count, digit_count_next;
  logic        leading_zero, leading_zero_next;
  logic [2:0]  dots_seen, dots_seen_next;
  logic        error_seen, error_seen_next;

  logic        is_digit;
  logic        is_dot;
  logic [3:0]  digit;
  logic [13:0] mac;
  logic        cur_ok;
  logic        new_ok;
  logic        ok;

  assign is_digit = (s1_item.character >= ipq_pkg::CHAR_ZERO) &&
                    (s1_item.character <= ipq_pkg::CHAR_NINE);
  assign is_dot   = (s1_item.character == ipq_pkg::CHAR_DOT);
  assign digit    = 4'(s1_item.character - ipq_pkg::CHAR_ZERO);
  // value * 10 + digit as shifts and adds
  assign mac      = {1'b0, octet_value, 3'b000} + {3'b000, octet_value, 1'b0}
                    + {10'd0, digit};

  assign cur_ok = (digit_count != 3'd0) && (digit_count <= ipq_pkg::DIGITS_MAX) &&
                  (octet_value <= ipq_pkg::OCTET_MAX);

  always_comb begin
    upper_octets_next = upper_octets;
    octet_value_next  = octet_value;
    digit_count_next  = digit_count;
    leading_zero_next = leading_zero;
    dots_seen_next    = dots_seen;
    error_seen_next   = error_seen;
    priority if (is_digit) begin
      if (digit_count == 3'd0) begin
        leading_zero_next = (digit == 4'd0);
      end else if (leading_zero) begin
        error_seen_next = 1'b1;
      end
      if (digit_count < ipq_pkg::DIGITS_MAX) begin
        octet_value_next = mac[9:0];
      end else begin
        error_seen_next = 1'b1;
      end
      if (digit_count < ipq_pkg::SAT_LIMIT) begin
        digit_count_next = digit_count + 3'd1;
      end
    end else if (is_dot) begin
      if (!cur_ok || (dots_seen >= ipq_pkg::DOTS_NEEDED)) begin
        error_seen_next = 1'b1;
      end else begin
        upper_octets_next = {upper_octets[15:0], octet_value[7:0]};
      end
      if (dots_seen < ipq_pkg::SAT_LIMIT) begin
        dots_seen_next = dots_seen + 3'd1;
      end
      octet_value_next  = 10'd0;
      digit_count_next  = 3'd0;
      leading_zero_next = 1'b0;
    end else begin
      error_seen_next = 1'b1;
    end
  end

  // verdict on the state after this character
  assign new_ok = (digit_count_next != 3'd0) &&
                  (digit_count_next <= ipq_pkg::DIGITS_MAX) &&
                  (octet_value_next <= ipq_pkg::OCTET_MAX);
  assign ok = !error_seen_next && (dots_seen_next == ipq_pkg::DOTS_NEEDED) && new_ok;

  assign result.valid_res = ok;
  assign result.address   = ok ? {upper_octets_next, octet_value_next[7:0]} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst || (adv && s1_item.final_char)) begin
      upper_octets <= 24'd0;
      octet_value  <= 10'd0;
      digit_count  <= 3'd0;
      leading_zero <= 1'b0;
      dots_seen    <= 3'd0;
      error_seen   <= 1'b0;
    end else if (adv) begin
      upper_octets <= upper_octets_next;
      octet_value  <= octet_value_next;
      digit_count  <= digit_count_next;
      leading_zero <= leading_zero_next;
      dots_seen    <= dots_seen_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule

>>> design/ipq_out_reg.sv
// Result register of the dotted-quad parser; holds a result under stall.
// Depends on ipq_pkg for the result type.
module ipq_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ipq_pkg::result_t result,
  input  logic             out_stall,
  output logic             out_valid,
  output ipq_pkg::result_t out_result
);

  logic out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= result;
    end
  end

endmodule

>>> design/ipv4_dotted_quad_parser.sv
// Top level of the strict IPv4 dotted-quad parser.
// Depends on ipq_pkg, ipq_in_reg, ipq_parse and ipq_out_reg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one ASCII character per
//   transaction; final_char marks the last character of an address string.
//   Output channel (out_valid / out_stall) carries one result transaction
//   per string: valid_res and the 32-bit address (first octet in 31..24,
//   zero when the string is not a strict dotted quad).
//   Characters without final_char produce no output transaction.
// Timing:
//   Throughput is one character per cycle unless a final character waits
//   behind a stalled result. A final character passes the input register,
//   then the state update and the result register, before out_valid.
// Reset (rst, synchronous): clears both valid flags and all parse state.
// Stall: a result held under out_stall keeps its value; non-final
//   characters keep flowing, and a final character waits in the input
//   register (raising in_stall) only while the held result is not taken.
module ipv4_dotted_quad_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  character,
  input  logic        final_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        valid_res,
  output logic [31:0] address
);

  ipq_pkg::item_t   in_item;
  ipq_pkg::item_t   s1_item;
  ipq_pkg::result_t result;
  ipq_pkg::result_t out_result;
  logic             s1_valid;
  logic             adv;

  assign in_item.character  = character;
  assign in_item.final_char = final_char;

  // Stage 1 moves on unless it holds a final character and the result
  // register is occupied and stalled.
  assign adv = s1_valid && (!s1_item.final_char || !out_valid || !out_stall);

  ipq_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ipq_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .s1_item (s1_item),
    .result  (result)
  );

  ipq_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (adv && s1_item.final_char),
    .result     (result),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  assign valid_res = out_result.valid_res;
  assign address   = out_result.address;

endmodule

>>> design/ipq_checker.sv
// Port-level checks for the dotted-quad parser, bound to the top level.
// Depends on ipv4_dotted_quad_parser.
module ipq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        valid_res,
  input logic [31:0] address
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(valid_res) && $stable(address))
    else $error("result changed under stall");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> address == 32'd0)
    else $error("invalid result with nonzero address");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("valid or stall after reset");

  a_backp: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

endmodule

bind ipv4_dotted_quad_parser ipq_checker u_ipq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .valid_res (valid_res),
  .address   (address)
);

>>> tb/tb_top.sv
// Self-checking testbench for the strict IPv4 dotted-quad parser.
// Streams address text, predicts each end-of-string result and checks it.
// Depends on ipq_pkg and ipv4_dotted_quad_parser.
`timescale 1ns / 100ps

module tb_top;

  // Stall-phase settings: percent chance of an idle cycle per side.
  localparam int SEND_IDLE_A = 30;
  localparam int RECV_IDLE_A = 63;
  localparam int CHARS_PER_PHASE = 250;
  localparam int LONG_HOLD = 300;     // receiver hold-off, in cycles
  localparam int TAIL_CYCLES = 8;     // settling margin at the end of drain()

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  character = 8'h00;
  logic        final_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        valid_res;
  logic [31:0] address;

  ipv4_dotted_quad_parser u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .character  (character),
    .final_char (final_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .valid_res  (valid_res),
    .address    (address)
  );

  always #5 clk = ~clk;

  // Stimulus and expectation stores.
  ipq_pkg::item_t   char_q[$];       // characters waiting to be driven
  ipq_pkg::result_t parsed_addrs[$]; // predicted results, oldest first
  logic [7:0]       text_buf[$];     // string under construction
  int               chars_pushed = 0;
  int               mismatches = 0;

  // Phase knobs, written by the sequencer at negedge only.
  int          phase = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // Predictor state, mirrors the parser's registers.
  logic [23:0] quad_hi = '0;     // octets closed by dots, latest in low byte
  logic [9:0]  cur_octet = '0;   // value of the digits of the open octet
  logic [2:0]  cur_digits = '0;  // digits in the open octet, saturating
  logic        cur_lead0 = 1'b0; // open octet started with '0'
  logic [2:0]  dot_count = '0;   // dots so far, saturating
  logic        bad_text = 1'b0;  // sticky violation flag for this string

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic octet_ok();
    return (cur_digits >= 3'd1) && (cur_digits <= ipq_pkg::DIGITS_MAX) &&
           (cur_octet <= ipq_pkg::OCTET_MAX);
  endfunction

  // Advances the predictor by one accepted character; on the final
  // character it queues the expected result and clears for the next string.
  task automatic parse_char(input ipq_pkg::item_t it);
    logic [3:0]       d;
    logic             ok;
    ipq_pkg::result_t r;
    if (it.character >= ipq_pkg::CHAR_ZERO && it.character <= ipq_pkg::CHAR_NINE) begin
      d = it.character[3:0];
      if (cur_digits == 3'd0) begin
        cur_lead0 = (d == 4'd0);
      end else if (cur_lead0) begin
        bad_text = 1'b1;
      end
      // Only the first three digits count toward the value.
      if (cur_digits < ipq_pkg::DIGITS_MAX) begin
        cur_octet = 10'(cur_octet * 10 + d);
      end else begin
        bad_text = 1'b1;
      end
      if (cur_digits < ipq_pkg::SAT_LIMIT) cur_digits = cur_digits + 3'd1;
    end else if (it.character == ipq_pkg::CHAR_DOT) begin
      // A bad octet or a fourth dot leaves the closed octets alone.
      if (!octet_ok() || dot_count >= ipq_pkg::DOTS_NEEDED) begin
        bad_text = 1'b1;
      end else begin
        quad_hi = {quad_hi[15:0], cur_octet[7:0]};
      end
      if (dot_count < ipq_pkg::SAT_LIMIT) dot_count = dot_count + 3'd1;
      cur_octet  = '0;
      cur_digits = '0;
      cur_lead0  = 1'b0;
    end else begin
      bad_text = 1'b1;
    end

    if (it.final_char) begin
      ok = !bad_text && (dot_count == ipq_pkg::DOTS_NEEDED) && octet_ok();
      r.valid_res = ok;
      r.address   = ok ? {quad_hi, cur_octet[7:0]} : 32'h0;
      parsed_addrs = {parsed_addrs, r};
      quad_hi    = '0;
      cur_octet  = '0;
      cur_digits = '0;
      cur_lead0  = 1'b0;
      dot_count  = '0;
      bad_text   = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Text builders
  // ---------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b);
    text_buf = {text_buf, b};
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // Decimal without leading zeros; zero prints as "0".
  task automatic put_num(input int v);
    int div;
    int started;
    started = 0;
    div = 1000;
    while (div > 0) begin
      if (started != 0 || (v / div) % 10 != 0 || div == 1) begin
        put_byte(ipq_pkg::CHAR_ZERO + 8'((v / div) % 10));
        started = 1;
      end
      div = div / 10;
    end
  endtask

  // Moves the built string into the drive queue, final mark on the last byte.
  task automatic flush_text();
    ipq_pkg::item_t it;
    for (int i = 0; i < text_buf.size(); i++) begin
      it.character  = text_buf[i];
      it.final_char = (i == text_buf.size() - 1);
      char_q = {char_q, it};
      chars_pushed++;
    end
    text_buf.delete();
  endtask

  task automatic send_str(input string s);
    put_str(s);
    flush_text();
  endtask

  function automatic logic [7:0] junk_char();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while ((b >= ipq_pkg::CHAR_ZERO && b <= ipq_pkg::CHAR_NINE) || b == ipq_pkg::CHAR_DOT)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic int pick_octet();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 9);
      1:       return ($urandom_range(0, 1) != 0) ? 255 : 0;
      2:       return $urandom_range(10, 99);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Well-formed quads with random octets; about half carry one flaw.
  task automatic put_random_quad();
    int flaw;
    int bad_k;
    int v;
    flaw  = $urandom_range(0, 13);   // 0..6 leave the quad clean
    bad_k = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      v = pick_octet();
      if (k == bad_k) begin
        case (flaw)
          7:  begin put_byte(ipq_pkg::CHAR_ZERO); put_num(v); end // leading zero
          8:  put_num($urandom_range(256, 999));                 // over 255
          9:  put_num($urandom_range(1000, 9999));               // four digits
          10: ;                                                  // empty octet
          11: begin put_num(v); put_byte(junk_char()); end       // stray byte
          13: begin put_num(v); put_byte(ipq_pkg::CHAR_DOT); end // extra dot
          default: put_num(v);
        endcase
      end else begin
        put_num(v);
      end
      // flaw 12 drops the dot after the chosen octet
      if (k < 3 && !(k == bad_k && flaw == 12)) put_byte(ipq_pkg::CHAR_DOT);
    end
    if (text_buf.size() == 0) put_byte(ipq_pkg::CHAR_ZERO);
    flush_text();
  endtask

  // Short strings of arbitrary bytes, biased toward digits and dots.
  task automatic put_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0, 1: put_byte(8'($urandom_range(0, 255)));
        2:    put_byte(ipq_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        default: put_byte(ipq_pkg::CHAR_DOT);
      endcase
    end
    flush_text();
  endtask

  task automatic fill_random(input int count);
    int goal;
    goal = chars_pushed + count;
    while (chars_pushed < goal) begin
      if ($urandom_range(0, 9) < 8) put_random_quad();
      else put_noise();
    end
  endtask

  // Sender pause: hold off until every queued character is taken and every
  // predicted result has come back, then allow for the pipeline latency.
  task automatic drain();
    while (char_q.size() != 0 || in_valid || parsed_addrs.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents the next character when the last one was taken and
  // the idle draw allows. A stalled transaction is held unchanged.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic           busy;
    ipq_pkg::item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        parse_char({character, final_char});
        busy = 1'b0;
      end
      if (!busy) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = char_q.pop_front();
          in_valid   <= 1'b1;
          character  <= nxt.character;
          final_char <= nxt.final_char;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every result transaction against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    ipq_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (parsed_addrs.size() == 0) begin
        $error("unexpected result: valid_res %0d address %08h", valid_res, address);
        mismatches++;
      end else begin
        want = parsed_addrs.pop_front();
        if (valid_res !== want.valid_res) begin
          $error("valid_res mismatch: expected %0d, actual %0d", want.valid_res, valid_res);
          mismatches++;
        end
        if (address !== want.address) begin
          $error("address mismatch: expected %08h, actual %08h", want.address, address);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver stall. Once, at the start of the no-idle phase, it holds off
  // for a long stretch so the sender fills the block and sees in_stall.
  // ---------------------------------------------------------------------
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (phase == 2 && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase 0: sender idles lightly, receiver heavily.
    phase = 0;
    send_idle_pct = SEND_IDLE_A;
    recv_idle_pct = RECV_IDLE_A;

    // Directed strings: field extremes and each violation class.
    send_str("0.0.0.0");
    send_str("255.255.255.255");
    send_str("1.2.3.4a");        // stray non-digit
    send_str("1234.1.1.1");      // four-digit octet
    send_str("01.1.1.1");        // digit after leading zero
    send_str("1..1.1");          // dot with no digits
    send_str("256.1.1.1");       // octet over 255
    send_str("1.1.1.1.1");       // fourth dot
    send_str("1.1.1.");          // ends on a dot
    send_str("1.1.1");           // too few dots
    send_str("1.1.1.300");       // last octet over 255
    send_str("7");
    put_byte(8'hFF);
    flush_text();
    put_byte(8'h00);
    flush_text();
    fill_random(CHARS_PER_PHASE - chars_pushed);
    drain();

    // Phase 1: roles swapped.
    phase = 1;
    send_idle_pct = RECV_IDLE_A;
    recv_idle_pct = SEND_IDLE_A;
    fill_random(CHARS_PER_PHASE);
    drain();

    // Phase 2: full rate both ways, plus the long receiver hold-off.
    phase = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(CHARS_PER_PHASE);
    drain();

    if (mismatches == 0 && parsed_addrs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> ipv4_dotted_quad_parser.f
design/ipq_pkg.sv
design/ipq_in_reg.sv
design/ipq_parse.sv
design/ipq_out_reg.sv
design/ipv4_dotted_quad_parser.sv
design/ipq_checker.sv
tb/tb_top.sv
